// File: rtl/core/union_find_spanning_forest_unit_macros.svh
// Assertion macros for the union-find spanning forest RTL.
`ifndef UNION_FIND_SPANNING_FOREST_UNIT_MACROS_SVH
`define UNION_FIND_SPANNING_FOREST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UFSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UFSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ufsf_pkg.sv
// Shared types and constants for the union-find spanning forest unit.
`timescale 1ns / 1ps

package ufsf_pkg;

    localparam int NODE_COUNT_DEFAULT = 256;
    localparam int PATH_DEPTH_DEFAULT = 8;

    localparam int IDX_W    = 7;
    localparam int SIDE_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int TOTAL_W  = 48;
    localparam int RAW_W    = 9;
    localparam int ALU_W    = 48;

    localparam logic [SIDE_W-1:0] SIDE_COUNT_RESET = 8'd128;

    typedef enum logic [1:0] {
        ALU_EQ,
        ALU_LT,
        ALU_ADD_SAT,
        ALU_SUB_GE
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               flag;
    } alu_rsp_t;

    typedef struct packed {
        logic parent_we;
        logic size_we;
    } mem_ctl_t;

endpackage

// File: rtl/core/ufsf_alu.sv
// Shared compare, saturating add and conditional subtract unit.
`timescale 1ns / 1ps

module ufsf_alu
(
    input  ufsf_pkg::alu_req_t req,
    output ufsf_pkg::alu_rsp_t rsp
);

    logic [ufsf_pkg::ALU_W:0] sum;
    logic [ufsf_pkg::ALU_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb
    begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
        unique case (req.op)
            ufsf_pkg::ALU_EQ:
            begin
                rsp.flag = (req.a == req.b);
            end
            ufsf_pkg::ALU_LT:
            begin
                rsp.flag = (req.a < req.b);
            end
            ufsf_pkg::ALU_ADD_SAT:
            begin
                rsp.flag = sum[ufsf_pkg::ALU_W];
                rsp.res  = sum[ufsf_pkg::ALU_W] ? '1 : sum[ufsf_pkg::ALU_W-1:0];
            end
            ufsf_pkg::ALU_SUB_GE:
            begin
                rsp.flag = !diff[ufsf_pkg::ALU_W];
                rsp.res  = diff[ufsf_pkg::ALU_W] ? req.a : diff[ufsf_pkg::ALU_W-1:0];
            end
        endcase
    end

endmodule

// File: rtl/core/ufsf_table_mem.sv
// Parent and component size tables with registered read data.
`timescale 1ns / 1ps

module ufsf_table_mem
#(
    parameter int NODE_COUNT = ufsf_pkg::NODE_COUNT_DEFAULT,
    localparam int NODE_W    = $clog2(NODE_COUNT),
    localparam int SIZE_W    = $clog2(NODE_COUNT + 1)
)
(
    input  logic                clk,
    input  ufsf_pkg::mem_ctl_t  ctl,
    input  logic [NODE_W-1:0]   raddr,
    input  logic [NODE_W-1:0]   parent_waddr,
    input  logic [NODE_W-1:0]   parent_wdata,
    input  logic [NODE_W-1:0]   size_waddr,
    input  logic [SIZE_W-1:0]   size_wdata,
    output logic [NODE_W-1:0]   parent_rdata,
    output logic [SIZE_W-1:0]   size_rdata
);

    logic [NODE_W-1:0] parent_mem [NODE_COUNT];
    logic [SIZE_W-1:0] size_mem   [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (ctl.parent_we)
        begin
            parent_mem[parent_waddr] <= parent_wdata;
        end
        if (ctl.size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        parent_rdata <= parent_mem[raddr];
        size_rdata   <= size_mem[raddr];
    end

endmodule

// File: rtl/core/ufsf_ctrl.sv
// Sequencer for table sweeps, index wrap, root walks, path compression, union and the running total.
`timescale 1ns / 1ps

module ufsf_ctrl
#(
    parameter int NODE_COUNT = ufsf_pkg::NODE_COUNT_DEFAULT,
    parameter int PATH_DEPTH = ufsf_pkg::PATH_DEPTH_DEFAULT,
    localparam int NODE_W    = $clog2(NODE_COUNT),
    localparam int SIZE_W    = $clog2(NODE_COUNT + 1)
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ufsf_pkg::SIDE_W-1:0]     side_count,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ufsf_pkg::IDX_W-1:0]      row_index,
    input  logic [ufsf_pkg::IDX_W-1:0]      column_index,
    input  logic [ufsf_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic                            first_edge,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            merged,
    output logic [ufsf_pkg::TOTAL_W-1:0]    cycle_weight_total,
    output logic                            total_saturated,
    output ufsf_pkg::mem_ctl_t              mem_ctl,
    output logic [NODE_W-1:0]               mem_raddr,
    output logic [NODE_W-1:0]               mem_parent_waddr,
    output logic [NODE_W-1:0]               mem_parent_wdata,
    output logic [NODE_W-1:0]               mem_size_waddr,
    output logic [SIZE_W-1:0]               mem_size_wdata,
    input  logic [NODE_W-1:0]               mem_parent_rdata,
    input  logic [SIZE_W-1:0]               mem_size_rdata
);

    localparam int HOP_W = $clog2(PATH_DEPTH + 1);
    localparam int RAW_W = ufsf_pkg::RAW_W;
    localparam int ALU_W = ufsf_pkg::ALU_W;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MOD_A,
        ST_MOD_B,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_CMP_TEST,
        ST_CMP_WR,
        ST_DECIDE,
        ST_TOTAL,
        ST_SZ_A,
        ST_SZ_B,
        ST_SZ_CMP,
        ST_UNION,
        ST_DONE
    } state_t;

    state_t                             state_reg;
    logic [NODE_W-1:0]                  clr_ptr_reg;
    logic [RAW_W-1:0]                   raw_reg;
    logic [RAW_W-1:0]                   b_raw_reg;
    logic [ufsf_pkg::WEIGHT_W-1:0]      weight_reg;
    logic [NODE_W-1:0]                  node_a_reg;
    logic [NODE_W-1:0]                  node_b_reg;
    logic                               phase_reg;
    logic [NODE_W-1:0]                  cur_reg;
    logic [HOP_W-1:0]                   hops_reg;
    logic [NODE_W-1:0]                  root_reg;
    logic [NODE_W-1:0]                  root_a_reg;
    logic [SIZE_W-1:0]                  size_a_reg;
    logic [SIZE_W-1:0]                  size_b_reg;
    logic [NODE_W-1:0]                  big_reg;
    logic [NODE_W-1:0]                  small_reg;
    logic [ufsf_pkg::TOTAL_W-1:0]       total_reg;
    logic                               sat_reg;
    logic                               merged_reg;
    logic                               out_valid_reg;
    logic                               out_merged_reg;
    logic [ufsf_pkg::TOTAL_W-1:0]       out_total_reg;
    logic                               out_sat_reg;

    ufsf_pkg::alu_req_t                 alu_req;
    ufsf_pkg::alu_rsp_t                 alu_rsp;
    logic [NODE_W-1:0]                  start_node;
    logic                               hop_limit;
    logic                               clr_last;

    ufsf_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign start_node = phase_reg ? node_b_reg : node_a_reg;
    assign hop_limit  = (hops_reg == HOP_W'(PATH_DEPTH));
    assign clr_last   = (clr_ptr_reg == NODE_W'(NODE_COUNT - 1));

    assign in_ready           = (state_reg == ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign merged             = out_merged_reg;
    assign cycle_weight_total = out_total_reg;
    assign total_saturated    = out_sat_reg;

    always_comb
    begin
        alu_req.op = ufsf_pkg::ALU_EQ;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            ST_MOD_A, ST_MOD_B:
            begin
                alu_req.op = ufsf_pkg::ALU_SUB_GE;
                alu_req.a  = ALU_W'(raw_reg);
                alu_req.b  = ALU_W'(NODE_COUNT);
            end
            ST_FIND_CHK:
            begin
                alu_req.a = ALU_W'(mem_parent_rdata);
                alu_req.b = ALU_W'(cur_reg);
            end
            ST_CMP_TEST:
            begin
                alu_req.a = ALU_W'(cur_reg);
                alu_req.b = ALU_W'(root_reg);
            end
            ST_DECIDE:
            begin
                alu_req.a = ALU_W'(root_a_reg);
                alu_req.b = ALU_W'(root_reg);
            end
            ST_TOTAL:
            begin
                alu_req.op = ufsf_pkg::ALU_ADD_SAT;
                alu_req.a  = total_reg;
                alu_req.b  = ALU_W'(weight_reg);
            end
            ST_SZ_CMP:
            begin
                alu_req.op = ufsf_pkg::ALU_LT;
                alu_req.a  = ALU_W'(size_a_reg);
                alu_req.b  = ALU_W'(mem_size_rdata);
            end
            ST_UNION:
            begin
                alu_req.op = ufsf_pkg::ALU_ADD_SAT;
                alu_req.a  = ALU_W'(size_a_reg);
                alu_req.b  = ALU_W'(size_b_reg);
            end
            default:
            begin
                alu_req.op = ufsf_pkg::ALU_EQ;
            end
        endcase
    end

    always_comb
    begin
        mem_ctl.parent_we = 1'b0;
        mem_ctl.size_we   = 1'b0;
        mem_parent_waddr  = cur_reg;
        mem_parent_wdata  = root_reg;
        mem_size_waddr    = big_reg;
        mem_size_wdata    = SIZE_W'(alu_rsp.res);
        unique case (state_reg)
            ST_FIND_RD:  mem_raddr = start_node;
            ST_FIND_CHK: mem_raddr = mem_parent_rdata;
            ST_SZ_A:     mem_raddr = root_a_reg;
            ST_SZ_B:     mem_raddr = root_reg;
            default:     mem_raddr = cur_reg;
        endcase
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_ctl.parent_we = 1'b1;
                mem_ctl.size_we   = 1'b1;
                mem_parent_waddr  = clr_ptr_reg;
                mem_parent_wdata  = clr_ptr_reg;
                mem_size_waddr    = clr_ptr_reg;
                mem_size_wdata    = SIZE_W'(1);
            end
            ST_CMP_WR:
            begin
                mem_ctl.parent_we = 1'b1;
            end
            ST_UNION:
            begin
                mem_ctl.parent_we = 1'b1;
                mem_ctl.size_we   = 1'b1;
                mem_parent_waddr  = small_reg;
                mem_parent_wdata  = big_reg;
            end
            default:
            begin
                mem_ctl.parent_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_ptr_reg   <= '0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            hops_reg      <= '0;
        end
        else
        begin
            if (out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    clr_ptr_reg <= clr_ptr_reg + NODE_W'(1);
                    if (clr_last)
                    begin
                        clr_ptr_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_reg    <= RAW_W'(row_index);
                        b_raw_reg  <= RAW_W'(side_count) + RAW_W'(column_index);
                        weight_reg <= edge_weight;
                        if (first_edge)
                        begin
                            total_reg <= '0;
                            sat_reg   <= 1'b0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_MOD_A;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + NODE_W'(1);
                    if (clr_last)
                    begin
                        clr_ptr_reg <= '0;
                        state_reg   <= ST_MOD_A;
                    end
                end
                ST_MOD_A:
                begin
                    if (alu_rsp.flag)
                    begin
                        raw_reg <= RAW_W'(alu_rsp.res);
                    end
                    else
                    begin
                        node_a_reg <= NODE_W'(raw_reg);
                        raw_reg    <= b_raw_reg;
                        state_reg  <= ST_MOD_B;
                    end
                end
                ST_MOD_B:
                begin
                    if (alu_rsp.flag)
                    begin
                        raw_reg <= RAW_W'(alu_rsp.res);
                    end
                    else
                    begin
                        node_b_reg <= NODE_W'(raw_reg);
                        phase_reg  <= 1'b0;
                        state_reg  <= ST_FIND_RD;
                    end
                end
                ST_FIND_RD:
                begin
                    cur_reg   <= start_node;
                    hops_reg  <= '0;
                    state_reg <= ST_FIND_CHK;
                end
                ST_FIND_CHK:
                begin
                    if (alu_rsp.flag || hop_limit)
                    begin
                        root_reg  <= cur_reg;
                        cur_reg   <= start_node;
                        hops_reg  <= '0;
                        state_reg <= ST_CMP_TEST;
                    end
                    else
                    begin
                        cur_reg  <= mem_parent_rdata;
                        hops_reg <= hops_reg + HOP_W'(1);
                    end
                end
                ST_CMP_TEST:
                begin
                    if (alu_rsp.flag || hop_limit)
                    begin
                        if (!phase_reg)
                        begin
                            root_a_reg <= root_reg;
                            phase_reg  <= 1'b1;
                            state_reg  <= ST_FIND_RD;
                        end
                        else
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_CMP_WR;
                    end
                end
                ST_CMP_WR:
                begin
                    cur_reg   <= mem_parent_rdata;
                    hops_reg  <= hops_reg + HOP_W'(1);
                    state_reg <= ST_CMP_TEST;
                end
                ST_DECIDE:
                begin
                    state_reg <= alu_rsp.flag ? ST_TOTAL : ST_SZ_A;
                end
                ST_TOTAL:
                begin
                    total_reg  <= alu_rsp.res;
                    sat_reg    <= sat_reg | alu_rsp.flag;
                    merged_reg <= 1'b0;
                    state_reg  <= ST_DONE;
                end
                ST_SZ_A:
                begin
                    state_reg <= ST_SZ_B;
                end
                ST_SZ_B:
                begin
                    size_a_reg <= mem_size_rdata;
                    state_reg  <= ST_SZ_CMP;
                end
                ST_SZ_CMP:
                begin
                    size_b_reg <= mem_size_rdata;
                    if (alu_rsp.flag)
                    begin
                        big_reg   <= root_reg;
                        small_reg <= root_a_reg;
                    end
                    else
                    begin
                        big_reg   <= root_a_reg;
                        small_reg <= root_reg;
                    end
                    state_reg <= ST_UNION;
                end
                ST_UNION:
                begin
                    merged_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_merged_reg <= merged_reg;
                        out_total_reg  <= total_reg;
                        out_sat_reg    <= sat_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/core/union_find_spanning_forest_unit.sv
// Union-find spanning forest unit: one result item per edge item, one item at a time.
// Each item wraps both node indices into range and walks both roots with path compression,
// then adds the edge weight to the running total if the roots match, or else merges the trees.
// A result not yet taken holds the next one.
// An item with first_edge set first clears the running total and sweeps the tables.
// After reset the tables are swept before the first item is taken.
`timescale 1ns / 1ps

`include "union_find_spanning_forest_unit_macros.svh"

module union_find_spanning_forest_unit
#(
    parameter int NODE_COUNT = ufsf_pkg::NODE_COUNT_DEFAULT,
    parameter int PATH_DEPTH = ufsf_pkg::PATH_DEPTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [ufsf_pkg::SIDE_W-1:0]     cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ufsf_pkg::IDX_W-1:0]      row_index,
    input  logic [ufsf_pkg::IDX_W-1:0]      column_index,
    input  logic [ufsf_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic                            first_edge,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            merged,
    output logic [ufsf_pkg::TOTAL_W-1:0]    cycle_weight_total,
    output logic                            total_saturated
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int SIZE_W = $clog2(NODE_COUNT + 1);

    logic [ufsf_pkg::SIDE_W-1:0]    side_count_reg;
    ufsf_pkg::mem_ctl_t             mem_ctl;
    logic [NODE_W-1:0]              mem_raddr;
    logic [NODE_W-1:0]              mem_parent_waddr;
    logic [NODE_W-1:0]              mem_parent_wdata;
    logic [NODE_W-1:0]              mem_size_waddr;
    logic [SIZE_W-1:0]              mem_size_wdata;
    logic [NODE_W-1:0]              mem_parent_rdata;
    logic [SIZE_W-1:0]              mem_size_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= ufsf_pkg::SIDE_COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            side_count_reg <= cfg_write_data;
        end
    end

    ufsf_ctrl
    #(
        .NODE_COUNT (NODE_COUNT),
        .PATH_DEPTH (PATH_DEPTH)
    )
    u_ctrl
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .side_count         (side_count_reg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .row_index          (row_index),
        .column_index       (column_index),
        .edge_weight        (edge_weight),
        .first_edge         (first_edge),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .merged             (merged),
        .cycle_weight_total (cycle_weight_total),
        .total_saturated    (total_saturated),
        .mem_ctl            (mem_ctl),
        .mem_raddr          (mem_raddr),
        .mem_parent_waddr   (mem_parent_waddr),
        .mem_parent_wdata   (mem_parent_wdata),
        .mem_size_waddr     (mem_size_waddr),
        .mem_size_wdata     (mem_size_wdata),
        .mem_parent_rdata   (mem_parent_rdata),
        .mem_size_rdata     (mem_size_rdata)
    );

    ufsf_table_mem
    #(
        .NODE_COUNT (NODE_COUNT)
    )
    u_table_mem
    (
        .clk          (clk),
        .ctl          (mem_ctl),
        .raddr        (mem_raddr),
        .parent_waddr (mem_parent_waddr),
        .parent_wdata (mem_parent_wdata),
        .size_waddr   (mem_size_waddr),
        .size_wdata   (mem_size_wdata),
        .parent_rdata (mem_parent_rdata),
        .size_rdata   (mem_size_rdata)
    );

    // An accepted item keeps the block busy for at least the following cycle.
    `UFSF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    // Once saturated, the reported total sits at its maximum.
    `UFSF_ASSERT_IMP(a_sat_max, out_valid && total_saturated, &cycle_weight_total, "total not full")
    // A new result item only appears from the busy sequencer.
    `UFSF_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result while idle")

endmodule
